/* hw/rtl/aeske_pkg.sv */
// Shared constants, types and the S-box table for the AES-128 key expansion unit.
`timescale 1ns / 1ps

package aeske_pkg;

    localparam int unsigned DEF_MAX_ROUNDS = 10;
    localparam int unsigned RC_W           = 4;
    localparam int unsigned WORD_W         = 32;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam int unsigned BCNT_W         = $clog2(BYTES_PER_WORD);

    localparam logic [RC_W-1:0]   RC_RESET   = 4'd10;
    localparam logic [BYTE_W-1:0] RCON_FIRST = 8'h01;
    localparam logic [BYTE_W-1:0] GF_POLY    = 8'h1b;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OUT,
        ST_CALC
    } state_t;

    localparam logic [BYTE_W-1:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [BYTE_W-1:0] gf_double(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] d;
        d = {v[BYTE_W-2:0], 1'b0};
        if (v[BYTE_W-1])
        begin
            d = d ^ GF_POLY;
        end
        return d;
    endfunction

endpackage

/* hw/rtl/aes128_key_expansion_unit.sv */
// AES-128 key expansion: byte-serial round key generator with valid/ready channels.
//
//  channel | direction | signals                                  | transfer
//  --------+-----------+------------------------------------------+---------------------
//  key in  | input     | in_valid/in_ready, key_word0..3          | valid && ready
//  keys out| output    | out_valid/out_ready, round_index,        | valid && ready
//          |           | round_word0..3, last_round               |
//  config  | input     | cfg_we, cfg_wdata (round_count)          | cfg_we at clock edge
//
// Round key 0 appears in the cycle after the key transaction. Each later round key is
// built in the byte lane (one S-box lookup and one byte of the XOR chain per cycle) and
// then held in the output register until it is taken. The single byte lane through the
// S-box limits the round key rate. Output stalls hold the block in place; one key is in
// work at a time. Reset initialises control state and sets round_count to 10.
`timescale 1ns / 1ps

module aes128_key_expansion_unit #(
    parameter int unsigned MAX_ROUNDS = aeske_pkg::DEF_MAX_ROUNDS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [aeske_pkg::WORD_W-1:0]  key_word0,
    input  logic [aeske_pkg::WORD_W-1:0]  key_word1,
    input  logic [aeske_pkg::WORD_W-1:0]  key_word2,
    input  logic [aeske_pkg::WORD_W-1:0]  key_word3,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [aeske_pkg::RC_W-1:0]    round_index,
    output logic [aeske_pkg::WORD_W-1:0]  round_word0,
    output logic [aeske_pkg::WORD_W-1:0]  round_word1,
    output logic [aeske_pkg::WORD_W-1:0]  round_word2,
    output logic [aeske_pkg::WORD_W-1:0]  round_word3,
    output logic                          last_round,
    input  logic                          cfg_we,
    input  logic [aeske_pkg::RC_W-1:0]    cfg_wdata
);

    import aeske_pkg::*;

    localparam logic [RC_W-1:0]   MAX_RC    = RC_W'(MAX_ROUNDS);
    localparam logic [BCNT_W-1:0] BCNT_LAST = BCNT_W'(BYTES_PER_WORD - 1);

    state_t              state_reg, state_next;
    logic [RC_W-1:0]     round_count_reg, round_count_next;
    logic [RC_W-1:0]     rounds_reg, rounds_next;
    logic [RC_W-1:0]     round_reg, round_next;
    logic [BCNT_W-1:0]   bcnt_reg, bcnt_next;
    logic [BYTE_W-1:0]   rcon_reg, rcon_next;
    logic [BYTE_W-1:0]   save_reg, save_next;
    logic [WORD_W-1:0]   w0_reg, w0_next;
    logic [WORD_W-1:0]   w1_reg, w1_next;
    logic [WORD_W-1:0]   w2_reg, w2_next;
    logic [WORD_W-1:0]   w3_reg, w3_next;

    logic [BYTE_W-1:0]   sb_in;
    logic [BYTE_W-1:0]   tb;
    logic [BYTE_W-1:0]   n0, n1, n2, n3;
    logic [RC_W-1:0]     rc_clamped;

    // Rotated last word: byte k+1 feeds lane k, the first byte wraps to the end.
    always_comb
    begin
        sb_in = (bcnt_reg == BCNT_LAST) ? save_reg : w3_reg[WORD_W-BYTE_W-1:WORD_W-2*BYTE_W];
        tb    = SBOX[sb_in] ^ ((bcnt_reg == '0) ? rcon_reg : '0);
        n0    = w0_reg[WORD_W-1:WORD_W-BYTE_W] ^ tb;
        n1    = w1_reg[WORD_W-1:WORD_W-BYTE_W] ^ n0;
        n2    = w2_reg[WORD_W-1:WORD_W-BYTE_W] ^ n1;
        n3    = w3_reg[WORD_W-1:WORD_W-BYTE_W] ^ n2;
    end

    always_comb
    begin
        priority if (round_count_reg == '0)
        begin
            rc_clamped = RC_W'(1);
        end
        else if (round_count_reg > MAX_RC)
        begin
            rc_clamped = MAX_RC;
        end
        else
        begin
            rc_clamped = round_count_reg;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        round_count_next = cfg_we ? cfg_wdata : round_count_reg;
        rounds_next      = rounds_reg;
        round_next       = round_reg;
        bcnt_next        = bcnt_reg;
        rcon_next        = rcon_reg;
        save_next        = save_reg;
        w0_next          = w0_reg;
        w1_next          = w1_reg;
        w2_next          = w2_reg;
        w3_next          = w3_reg;
        in_ready         = 1'b0;
        out_valid        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    w0_next     = key_word0;
                    w1_next     = key_word1;
                    w2_next     = key_word2;
                    w3_next     = key_word3;
                    rounds_next = rc_clamped;
                    round_next  = '0;
                    rcon_next   = RCON_FIRST;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    bcnt_next  = '0;
                    state_next = (round_reg == rounds_reg) ? ST_IDLE : ST_CALC;
                end
            end
            ST_CALC:
            begin
                // Shift each word one byte left, new byte enters at the bottom.
                w0_next   = {w0_reg[WORD_W-BYTE_W-1:0], n0};
                w1_next   = {w1_reg[WORD_W-BYTE_W-1:0], n1};
                w2_next   = {w2_reg[WORD_W-BYTE_W-1:0], n2};
                w3_next   = {w3_reg[WORD_W-BYTE_W-1:0], n3};
                bcnt_next = bcnt_reg + BCNT_W'(1);
                if (bcnt_reg == '0)
                begin
                    save_next = w3_reg[WORD_W-1:WORD_W-BYTE_W];
                end
                if (bcnt_reg == BCNT_LAST)
                begin
                    round_next = round_reg + RC_W'(1);
                    rcon_next  = gf_double(rcon_reg);
                    state_next = ST_OUT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            round_count_reg <= RC_RESET;
            rounds_reg      <= RC_W'(1);
            round_reg       <= '0;
            bcnt_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            round_count_reg <= round_count_next;
            rounds_reg      <= rounds_next;
            round_reg       <= round_next;
            bcnt_reg        <= bcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rcon_reg <= rcon_next;
        save_reg <= save_next;
        w0_reg   <= w0_next;
        w1_reg   <= w1_next;
        w2_reg   <= w2_next;
        w3_reg   <= w3_next;
    end

    assign round_index = round_reg;
    assign round_word0 = w0_reg;
    assign round_word1 = w1_reg;
    assign round_word2 = w2_reg;
    assign round_word3 = w3_reg;
    assign last_round  = (round_reg == rounds_reg);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while a round key is pending");

    a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (round_index <= rounds_reg && rounds_reg <= MAX_RC
                       && rounds_reg != '0))
        else $error("round index beyond expansion length");

    a_first_key: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (out_valid && round_index == '0))
        else $error("round key 0 not presented after key transaction");

    a_next_round: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_round) |=> (!out_valid && !in_ready))
        else $error("expansion ended early");

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_round) |=> in_ready)
        else $error("block not idle after final round key");
`endif

endmodule

/* bench/aes128_key_expansion_unit_tb.sv */
// Self-checking testbench for the AES-128 key expansion unit.
`timescale 1ns / 1ps

module aes128_key_expansion_unit_tb;

    import aeske_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned PHASES       = 16;
    localparam int unsigned PHASE_KEYS   = 24;
    localparam int unsigned REPORT_LIMIT = 40;

    typedef struct packed {
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
    } cipher_key_t;

    typedef struct packed {
        logic [RC_W-1:0]   index;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
        logic              last;
    } round_key_t;

    class round_key_scoreboard;
        round_key_t      pending_round_keys[$];
        logic [RC_W-1:0] round_count;
        int unsigned     mismatches;
        int unsigned     keys_expanded;
        int unsigned     round_keys_checked;
        bit              counts_written[16];

        function new();
            round_count        = RC_RESET;
            mismatches         = 0;
            keys_expanded      = 0;
            round_keys_checked = 0;
        endfunction

        function void set_round_count(logic [RC_W-1:0] v);
            round_count       = v;
            counts_written[v] = 1'b1;
        endfunction

        // Expand one accepted key into the round keys the block must emit.
        function void note_key(cipher_key_t k);
            logic [WORD_W-1:0] w[4];
            logic [WORD_W-1:0] t;
            logic [BYTE_W-1:0] rcon;
            int unsigned       n_rounds;
            round_key_t        rk;
            n_rounds = round_count;
            if (n_rounds < 1)
            begin
                n_rounds = 1;
            end
            if (n_rounds > DEF_MAX_ROUNDS)
            begin
                n_rounds = DEF_MAX_ROUNDS;
            end
            w[0] = k.w0;
            w[1] = k.w1;
            w[2] = k.w2;
            w[3] = k.w3;
            rcon = RCON_FIRST;
            for (int r = 0; r <= n_rounds; r++)
            begin
                if (r > 0)
                begin
                    t = {w[3][23:0], w[3][31:24]};
                    t = {SBOX[t[31:24]], SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]]}
                        ^ {rcon, 24'h000000};
                    rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? GF_POLY : 8'h00);
                    // chain the XOR through the previous round key
                    for (int i = 0; i < 4; i++)
                    begin
                        w[i] = w[i] ^ t;
                        t    = w[i];
                    end
                end
                rk.index = RC_W'(r);
                rk.w0    = w[0];
                rk.w1    = w[1];
                rk.w2    = w[2];
                rk.w3    = w[3];
                rk.last  = (r == n_rounds);
                pending_round_keys.push_back(rk);
            end
            keys_expanded++;
        endfunction

        function void compare_field(string field, logic [RC_W-1:0] idx,
                                    logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: round %0d %s expected %h actual %h",
                             $time, idx, field, want, got);
                end
            end
        endfunction

        function void check_round_key(round_key_t got);
            round_key_t want;
            round_keys_checked++;
            if (pending_round_keys.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: unexpected round key expected none actual %h",
                             $time, got);
                end
                return;
            end
            want = pending_round_keys.pop_front();
            compare_field("round_index", want.index, WORD_W'(want.index), WORD_W'(got.index));
            compare_field("round_word0", want.index, want.w0, got.w0);
            compare_field("round_word1", want.index, want.w1, got.w1);
            compare_field("round_word2", want.index, want.w2, got.w2);
            compare_field("round_word3", want.index, want.w3, got.w3);
            compare_field("last_round", want.index, WORD_W'(want.last), WORD_W'(got.last));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [WORD_W-1:0]   key_word0;
    logic [WORD_W-1:0]   key_word1;
    logic [WORD_W-1:0]   key_word2;
    logic [WORD_W-1:0]   key_word3;
    logic                out_valid;
    logic                out_ready;
    logic [RC_W-1:0]     round_index;
    logic [WORD_W-1:0]   round_word0;
    logic [WORD_W-1:0]   round_word1;
    logic [WORD_W-1:0]   round_word2;
    logic [WORD_W-1:0]   round_word3;
    logic                last_round;
    logic                cfg_we;
    logic [RC_W-1:0]     cfg_wdata;

    bit                  steady       = 1'b0;
    bit                  hold_request = 1'b0;
    round_key_scoreboard sb           = new();

    aes128_key_expansion_unit #(
        .MAX_ROUNDS(DEF_MAX_ROUNDS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .key_word0  (key_word0),
        .key_word1  (key_word1),
        .key_word2  (key_word2),
        .key_word3  (key_word3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .round_index(round_index),
        .round_word0(round_word0),
        .round_word1(round_word1),
        .round_word2(round_word2),
        .round_word3(round_word3),
        .last_round (last_round),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random back-pressure, or a long hold when requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < 12)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            sb.check_round_key('{round_index, round_word0, round_word1,
                                 round_word2, round_word3, last_round});
        end
    end

    task automatic send_key(input cipher_key_t k);
        if (!steady && $urandom_range(0, 99) < 25)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        key_word0 <= k.w0;
        key_word1 <= k.w1;
        key_word2 <= k.w2;
        key_word3 <= k.w3;
        @(posedge clk);
        while (in_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        sb.note_key(k);
    endtask

    // Drop valid and wait until every round key has come out, then let the block settle.
    task automatic drain_round_keys();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_round_keys.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_round_count(input logic [RC_W-1:0] v);
        drain_round_keys();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_round_count(v);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic cipher_key_t random_key();
        cipher_key_t k;
        k.w0 = random_word();
        k.w1 = random_word();
        k.w2 = random_word();
        k.w3 = random_word();
        return k;
    endfunction

    initial
    begin
        cipher_key_t     directed[$];
        logic [RC_W-1:0] phase_count;
        int unsigned     distinct_counts;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        key_word0 = '0;
        key_word1 = '0;
        key_word2 = '0;
        key_word3 = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Known keys at the reset round count of ten.
        directed.push_back('{32'h2b7e1516, 32'h28aed2a6, 32'habf71588, 32'h09cf4f3c});
        directed.push_back('{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000});
        directed.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
        directed.push_back('{32'h80000000, 32'h00000001, 32'h80000000, 32'h00000001});
        directed.push_back('{32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa});
        directed.push_back('{32'h00010203, 32'h04050607, 32'h08090a0b, 32'h0c0d0e0f});
        directed.push_back('{32'h00000000, 32'h00000000, 32'h00000000, 32'hff00ff00});
        directed.push_back('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h00ff00ff});
        foreach (directed[i])
        begin
            send_key(directed[i]);
        end

        // Round count zero acts as one; counts past the maximum saturate.
        write_round_count(RC_W'(0));
        send_key(directed[0]);
        send_key(directed[2]);
        write_round_count(RC_W'(1));
        send_key(directed[0]);
        send_key(directed[1]);
        write_round_count(RC_W'(15));
        send_key(directed[0]);
        send_key(directed[3]);
        write_round_count(RC_W'(11));
        send_key(directed[5]);
        write_round_count(RC_RESET);
        send_key(directed[4]);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                phase_count = RC_W'(DEF_MAX_ROUNDS);
            end
            else if (p == 1)
            begin
                phase_count = RC_W'(1);
            end
            else
            begin
                phase_count = RC_W'($urandom_range(0, 15));
            end
            write_round_count(phase_count);
            steady = (p == 3);
            if (p == 5)
            begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_KEYS; n++)
            begin
                // hold the sender until the block has emptied
                if (p == 8 && n == PHASE_KEYS / 2)
                begin
                    drain_round_keys();
                end
                send_key(random_key());
            end
            steady = 1'b0;
        end

        drain_round_keys();

        distinct_counts = 0;
        foreach (sb.counts_written[i])
        begin
            distinct_counts += sb.counts_written[i];
        end
        $display("Expanded %0d cipher keys into %0d round keys.",
                 sb.keys_expanded, sb.round_keys_checked);
        $display("Round count took %0d distinct values, with back-pressure and idle gaps.",
                 distinct_counts);
        if (sb.mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
